// ===== design/sbcu_pkg.sv =====
// ----------------------------------------------------------------------------
// sbcu_pkg
// Command, fault and state codes and fixed field widths shared by the
// script branch and call unit.
// ----------------------------------------------------------------------------
package sbcu_pkg;

    localparam int RND_W  = 15;
    localparam int SPAN_W = 17;

    typedef enum logic [3:0] {
        CMD_JMP  = 4'd0,
        CMD_JGE  = 4'd1,
        CMD_JGT  = 4'd2,
        CMD_JEQ  = 4'd3,
        CMD_JNE  = 4'd4,
        CMD_BTW  = 4'd5,
        CMD_RJMP = 4'd6,
        CMD_CALL = 4'd7,
        CMD_RET  = 4'd8,
        CMD_SETR = 4'd9,
        CMD_SUB  = 4'd10
    } t_cmd;

    typedef enum logic [2:0] {
        F_OK        = 3'd0,
        F_OVERFLOW  = 3'd1,
        F_UNDERFLOW = 3'd2,
        F_SPAN      = 3'd3,
        F_HALTED    = 3'd4
    } t_fault;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_AB,
        S_RD_C,
        S_EXEC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== design/sbcu_rem.sv =====
// ----------------------------------------------------------------------------
// sbcu_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sbcu_rem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sbcu_pkg::RND_W-1:0]  i_dividend,
    input  logic [sbcu_pkg::SPAN_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sbcu_pkg::SPAN_W-1:0] o_remainder
);
    import sbcu_pkg::*;

    localparam int CW = $clog2(RND_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [RND_W-1:0]  r_num;
    logic [SPAN_W-1:0] r_div;
    logic [SPAN_W-1:0] r_rem;
    logic [SPAN_W-1:0] n_shift;
    logic [SPAN_W-1:0] n_rem;

    always_comb begin
        n_shift = {r_rem[SPAN_W-2:0], r_num[RND_W-1]};
        n_rem   = (n_shift >= r_div) ? (n_shift - r_div) : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// ===== design/script_branch_call_unit_top.sv =====
// ----------------------------------------------------------------------------
// script_branch_call_unit_top
// Executes one decoded script instruction against a register file and a
// return stack, producing the next address, a taken flag and a fault code.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. Register reads go through a
// two-read, one-write synchronous memory with registered read data: the
// two source registers are read first, then the third, then the instruction
// executes. For most commands the unit then moves to its output step, which
// registers the result; the next instruction is accepted once the unit is
// back in idle. Random jump takes its percent remainder with a reciprocal
// multiply during the read steps and adds no time. Set random adds a 15-step
// bit-serial remainder unit for its data-dependent span between the execute
// and output steps. A waiting result that is stalled holds the unit in its
// output step. Registers read as zero until first written (one valid bit per
// register); no clearing pass is needed after reset. A fault halts the unit:
// every later instruction reports the halted fault until reset.
module script_branch_call_unit_top #(
    parameter int REG_COUNT     = 256,
    parameter int STACK_SLOTS   = 16,
    parameter int PERCENT_SCALE = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_code_base,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_reg_a,
    input  logic [7:0]  i_reg_b,
    input  logic [7:0]  i_reg_c,
    input  logic [15:0] i_jump_offset,
    input  logic signed [15:0] i_range_low,
    input  logic signed [15:0] i_range_high,
    input  logic [14:0] i_random_value,
    input  logic [31:0] i_fall_through_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_next_address,
    output logic        o_branch_taken,
    output logic [2:0]  o_fault
);
    import sbcu_pkg::*;

    localparam int RW = $clog2(REG_COUNT);
    localparam int DW = $clog2(STACK_SLOTS + 1);
    localparam int SW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam logic [8:0] REG_LIM = 9'(REG_COUNT);
    localparam logic [63:0] PCT_NUM = 64'h1_0000_0000 + 64'(PERCENT_SCALE) - 64'd1;
    localparam logic [31:0] PCT_RECIP = 32'(PCT_NUM / 64'(PERCENT_SCALE));

    t_state r_state, n_state;

    logic [31:0] r_base;
    logic        r_halted;
    logic [DW-1:0] r_depth;
    logic        r_vld [REG_COUNT];
    logic        r_out_valid;

    logic [3:0]  r_cmd;
    logic [7:0]  r_ra, r_rb, r_rc;
    logic [15:0] r_off;
    logic signed [15:0] r_lo, r_hi;
    logic [14:0] r_rnd;
    logic [31:0] r_fall;

    logic signed [31:0] r_a, r_b;
    logic [31:0] r_res_next;
    logic        r_res_taken;
    logic [2:0]  r_res_fault;
    logic [31:0] r_out_next;
    logic        r_out_taken;
    logic [2:0]  r_out_fault;

    logic [31:0] r_rf [REG_COUNT];
    logic [31:0] r_rf_q0, r_rf_q1;
    logic        r_z0, r_z1;
    logic [31:0] r_stack [STACK_SLOTS];
    logic [31:0] r_stk_q;

    logic [RND_W-1:0] r_pct_q;
    logic [RND_W-1:0] r_pct_rem;

    logic [RW-1:0] rf_ra0, rf_ra1, rf_waddr;
    logic          ra0_ok, ra1_ok;
    logic          rf_we;
    logic [31:0]   rf_wdata;
    logic [SW-1:0] stk_ra, stk_wa;
    logic          stk_we;
    logic          div_start;
    logic [SPAN_W-1:0] div_divisor;
    logic          div_done;
    logic [SPAN_W-1:0] div_rem;

    logic          in_acc;
    logic          out_free;
    logic          c_ok;
    logic signed [31:0] c_val;
    logic signed [17:0] span;
    logic          span_ok;
    logic [31:0]   target;
    logic [31:0]   ex_tgt;
    logic          ex_cond;
    t_fault        ex_fault;
    logic [RND_W+31:0] pct_prod;
    logic [31:0]   pct_back;
    logic          pct_lt;
    logic signed [31:0] rnd_val;
    logic [DW-1:0] depth_m1;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign c_ok        = {1'b0, r_rc} < REG_LIM;
    assign c_val       = r_z0 ? 32'sd0 : $signed(r_rf_q0);
    assign span        = 18'(r_hi) - 18'(r_lo) + 18'sd1;
    assign span_ok     = span > 18'sd0;
    assign target      = r_base + 32'(r_off);
    assign ex_tgt      = (t_cmd'(r_cmd) == CMD_RET) ? r_stk_q : target;
    assign pct_prod    = {32'b0, r_rnd} * {{RND_W{1'b0}}, PCT_RECIP};
    assign pct_back    = 32'(r_pct_q) * 32'(PERCENT_SCALE);
    assign pct_lt      = $signed({{(32 - RND_W){1'b0}}, r_pct_rem}) < r_a;
    assign rnd_val     = 32'(r_lo) + $signed({{(32 - SPAN_W){1'b0}}, div_rem});
    assign depth_m1    = r_depth - 1'b1;
    assign stk_ra      = depth_m1[SW-1:0];
    assign stk_wa      = r_depth[SW-1:0];

    always_comb begin
        ex_cond  = 1'b0;
        ex_fault = F_OK;
        if (r_halted) begin
            ex_fault = F_HALTED;
        end else begin
            case (t_cmd'(r_cmd))
                CMD_JMP: ex_cond = 1'b1;
                CMD_JGE: ex_cond = r_a >= r_b;
                CMD_JGT: ex_cond = r_a > r_b;
                CMD_JEQ: ex_cond = r_a == r_b;
                CMD_JNE: ex_cond = r_a != r_b;
                CMD_BTW: ex_cond = (r_a <= r_b) && (c_val <= r_a);
                CMD_RJMP: ex_cond = pct_lt;
                CMD_CALL: begin
                    if (r_depth >= DW'(STACK_SLOTS)) ex_fault = F_OVERFLOW;
                    else ex_cond = 1'b1;
                end
                CMD_RET: begin
                    if (r_depth == '0) ex_fault = F_UNDERFLOW;
                    else ex_cond = 1'b1;
                end
                CMD_SETR: begin
                    if (!span_ok) ex_fault = F_SPAN;
                end
                default: ex_cond = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_RD_AB;
            S_RD_AB: n_state = S_RD_C;
            S_RD_C:  n_state = S_EXEC;
            S_EXEC: begin
                if (!r_halted && t_cmd'(r_cmd) == CMD_SETR && span_ok) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV:   if (div_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = r_state != S_IDLE;
        rf_ra0      = r_ra[RW-1:0];
        ra0_ok      = {1'b0, r_ra} < REG_LIM;
        rf_ra1      = r_rb[RW-1:0];
        ra1_ok      = {1'b0, r_rb} < REG_LIM;
        rf_we       = 1'b0;
        rf_waddr    = r_rc[RW-1:0];
        rf_wdata    = 32'(r_a) - 32'(r_b);
        stk_we      = 1'b0;
        div_start   = 1'b0;
        div_divisor = span[SPAN_W-1:0];
        case (r_state)
            S_RD_C: begin
                rf_ra0 = r_rc[RW-1:0];
                ra0_ok = c_ok;
            end
            S_EXEC: begin
                if (!r_halted) begin
                    case (t_cmd'(r_cmd))
                        CMD_SETR: div_start = span_ok;
                        CMD_SUB:  rf_we = c_ok;
                        CMD_CALL: stk_we = ex_fault == F_OK;
                        default:  div_start = 1'b0;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done && t_cmd'(r_cmd) == CMD_SETR) begin
                    rf_we    = c_ok;
                    rf_wdata = 32'(rnd_val);
                end
            end
            default: rf_we = 1'b0;
        endcase
    end

    sbcu_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_rnd),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        r_rf_q0 <= r_rf[rf_ra0];
        r_rf_q1 <= r_rf[rf_ra1];
        r_z0    <= !(ra0_ok && r_vld[rf_ra0]);
        r_z1    <= !(ra1_ok && r_vld[rf_ra1]);
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= r_fall;
        end
        r_stk_q <= r_stack[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_halted    <= 1'b0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_code_base;
            end
            if (rf_we) begin
                r_vld[rf_waddr] <= 1'b1;
            end
            if (r_state == S_EXEC) begin
                if (ex_fault != F_OK) begin
                    r_halted <= 1'b1;
                end else if (t_cmd'(r_cmd) == CMD_CALL) begin
                    r_depth <= r_depth + 1'b1;
                end else if (t_cmd'(r_cmd) == CMD_RET) begin
                    r_depth <= depth_m1;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_ra   <= i_reg_a;
            r_rb   <= i_reg_b;
            r_rc   <= i_reg_c;
            r_off  <= i_jump_offset;
            r_lo   <= i_range_low;
            r_hi   <= i_range_high;
            r_rnd  <= i_random_value;
            r_fall <= i_fall_through_address;
        end
        if (r_state == S_RD_AB) begin
            r_pct_q <= pct_prod[RND_W+31:32];
        end
        if (r_state == S_RD_C) begin
            r_a       <= r_z0 ? 32'sd0 : $signed(r_rf_q0);
            r_b       <= r_z1 ? 32'sd0 : $signed(r_rf_q1);
            r_pct_rem <= r_rnd - pct_back[RND_W-1:0];
        end
        if (r_state == S_EXEC) begin
            r_res_next  <= (ex_fault == F_OK && ex_cond) ? ex_tgt : r_fall;
            r_res_taken <= ex_fault == F_OK && ex_cond;
            r_res_fault <= ex_fault;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_next  <= r_res_next;
            r_out_taken <= r_res_taken;
            r_out_fault <= r_res_fault;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_address = r_out_next;
    assign o_branch_taken = r_out_taken;
    assign o_fault        = r_out_fault;

endmodule

// ===== bench/script_branch_call_unit_top_tb.sv =====
// ----------------------------------------------------------------------------
// script_branch_call_unit_top_tb
// Drives decoded script instructions into the branch and call unit with
// random idle gaps on both sides. It predicts each result from its own copy
// of the register file, return stack and code base, and checks every
// transaction field by field. The run ends with a single halting fault,
// followed by instructions that must report the halted state.
// ----------------------------------------------------------------------------
module script_branch_call_unit_top_tb;

    import sbcu_pkg::*;

    localparam int REG_COUNT      = 256;
    localparam int STACK_SLOTS    = 16;
    localparam int PERCENT_SCALE  = 100;
    localparam int CLK_HALF       = 4;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int SETTLE_CYCLES  = 32;
    localparam int TIMEOUT_CYCLES = 1_200_000;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 305;
    localparam int HALTED_ITEMS   = 20;

    localparam logic [3:0] CMD_SPARE_FIRST = 4'(CMD_SUB) + 4'd1;
    localparam logic [3:0] CMD_SPARE_LAST  = 4'hF;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [7:0]         ra;
        logic [7:0]         rb;
        logic [7:0]         rc;
        logic [15:0]        off;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [14:0]        rnd;
        logic [31:0]        fall;
    } t_instr;

    typedef struct packed {
        logic [31:0] next_addr;
        logic        taken;
        logic [2:0]  fault;
    } t_result;

    class script_exec_model;
        logic [31:0] code_base;
        int          regs [REG_COUNT];
        logic [31:0] ret_stack [STACK_SLOTS];
        int          depth;
        bit          halted;
        int          mismatches;
        t_result     expected_results [$];

        function new();
            code_base = '0;
            foreach (regs[i]) regs[i] = 0;
            depth      = 0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        function int read_reg(logic [7:0] idx);
            return (int'(idx) < REG_COUNT) ? regs[idx] : 0;
        endfunction

        function void write_reg(logic [7:0] idx, int value);
            if (int'(idx) < REG_COUNT) regs[idx] = value;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void note_instr(t_instr t);
            t_result     r;
            logic [31:0] target;
            int          a;
            int          b;
            int          c;
            int          span;
            bit          cond;
            r.next_addr = t.fall;
            r.taken     = 1'b0;
            r.fault     = F_OK;
            cond        = 1'b0;
            target      = code_base + 32'(t.off);
            if (halted) begin
                r.fault = F_HALTED;
            end else begin
                a = read_reg(t.ra);
                b = read_reg(t.rb);
                c = read_reg(t.rc);
                case (t.cmd)
                    CMD_JMP:  cond = 1'b1;
                    CMD_JGE:  cond = a >= b;
                    CMD_JGT:  cond = a > b;
                    CMD_JEQ:  cond = a == b;
                    CMD_JNE:  cond = a != b;
                    CMD_BTW:  cond = (a <= b) && (c <= a);
                    CMD_RJMP: cond = (int'(t.rnd) % PERCENT_SCALE) < a;
                    CMD_CALL: begin
                        if (depth >= STACK_SLOTS) begin
                            r.fault = F_OVERFLOW;
                        end else begin
                            ret_stack[depth] = t.fall;
                            depth++;
                            cond = 1'b1;
                        end
                    end
                    CMD_RET: begin
                        if (depth == 0) begin
                            r.fault = F_UNDERFLOW;
                        end else begin
                            depth--;
                            target = ret_stack[depth];
                            cond   = 1'b1;
                        end
                    end
                    CMD_SETR: begin
                        span = int'($signed(t.hi)) - int'($signed(t.lo)) + 1;
                        if (span <= 0) begin
                            r.fault = F_SPAN;
                        end else begin
                            write_reg(t.rc, (int'(t.rnd) % span) + int'($signed(t.lo)));
                        end
                    end
                    CMD_SUB:  write_reg(t.rc, a - b);
                    default: ;
                endcase
                if (r.fault != F_OK) begin
                    halted = 1'b1;
                end else if (cond) begin
                    r.next_addr = target;
                    r.taken     = 1'b1;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_results.size() == 0) begin
                $error("unexpected result: next_address=%h branch_taken=%0d fault=%0d",
                       got.next_addr, got.taken, got.fault);
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.next_addr !== exp.next_addr) begin
                $error("next_address: expected %h, actual %h", exp.next_addr, got.next_addr);
                mismatches++;
            end
            if (got.taken !== exp.taken) begin
                $error("branch_taken: expected %0d, actual %0d", exp.taken, got.taken);
                mismatches++;
            end
            if (got.fault !== exp.fault) begin
                $error("fault: expected %0d, actual %0d", exp.fault, got.fault);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_code_base;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [3:0]         i_cmd;
    logic [7:0]         i_reg_a;
    logic [7:0]         i_reg_b;
    logic [7:0]         i_reg_c;
    logic [15:0]        i_jump_offset;
    logic signed [15:0] i_range_low;
    logic signed [15:0] i_range_high;
    logic [14:0]        i_random_value;
    logic [31:0]        i_fall_through_address;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [31:0]        o_next_address;
    logic               o_branch_taken;
    logic [2:0]         o_fault;

    script_exec_model exec_model;
    bit               sender_quiet   = 1'b0;
    bit               receiver_quiet = 1'b0;
    int               call_bias      = 50;

    script_branch_call_unit_top #(
        .REG_COUNT     (REG_COUNT),
        .STACK_SLOTS   (STACK_SLOTS),
        .PERCENT_SCALE (PERCENT_SCALE)
    ) u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_code_base        (i_cfg_code_base),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_cmd                  (i_cmd),
        .i_reg_a                (i_reg_a),
        .i_reg_b                (i_reg_b),
        .i_reg_c                (i_reg_c),
        .i_jump_offset          (i_jump_offset),
        .i_range_low            (i_range_low),
        .i_range_high           (i_range_high),
        .i_random_value         (i_random_value),
        .i_fall_through_address (i_fall_through_address),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_next_address         (o_next_address),
        .o_branch_taken         (o_branch_taken),
        .o_fault                (o_fault)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_reg();
        return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(0, 255));
    endfunction

    task automatic issue(input logic [3:0] cmd, input logic [7:0] ra, input logic [7:0] rb,
                         input logic [7:0] rc, input logic [15:0] off,
                         input logic signed [15:0] lo, input logic signed [15:0] hi,
                         input logic [14:0] rnd, input logic [31:0] fall);
        t_instr t;
        int     gap;
        t = '{cmd, ra, rb, rc, off, lo, hi, rnd, fall};
        @(negedge i_clk);
        i_cmd                  <= cmd;
        i_reg_a                <= ra;
        i_reg_b                <= rb;
        i_reg_c                <= rc;
        i_jump_offset          <= off;
        i_range_low            <= lo;
        i_range_high           <= hi;
        i_random_value         <= rnd;
        i_fall_through_address <= fall;
        i_in_valid             <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        exec_model.note_instr(t);
        if (!sender_quiet && $urandom_range(0, 1) == 0) begin
            gap = pick_gap();
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic issue_cmd(input logic [3:0] cmd);
        logic [7:0]         ra;
        logic [7:0]         rb;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] tmp;
        ra = pick_reg();
        rb = ($urandom_range(0, 9) == 0) ? ra : pick_reg();
        case ($urandom_range(0, 9))
            0: begin
                lo = 16'sh8000;
                hi = 16'sh7FFF;
            end
            1, 2: begin
                lo = 16'($urandom);
                hi = lo + 16'($urandom_range(0, 9));
                if (hi < lo) hi = 16'sh7FFF;
            end
            3, 4: begin
                lo = 16'($urandom_range(0, 10)) - 16'sd5;
                hi = 16'($urandom_range(0, 120));
                if (hi < lo) hi = lo;
            end
            default: begin
                lo = 16'($urandom);
                hi = 16'($urandom);
                if (hi < lo) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
        endcase
        issue(cmd, ra, rb, pick_reg(), 16'($urandom), lo, hi, 15'($urandom), $urandom);
    endtask

    task automatic random_instr();
        int         sel;
        logic [3:0] cmd;
        sel = $urandom_range(0, 99);
        if      (sel < 6)  cmd = CMD_JMP;
        else if (sel < 12) cmd = CMD_JGE;
        else if (sel < 18) cmd = CMD_JGT;
        else if (sel < 24) cmd = CMD_JEQ;
        else if (sel < 30) cmd = CMD_JNE;
        else if (sel < 37) cmd = CMD_BTW;
        else if (sel < 45) cmd = CMD_RJMP;
        else if (sel < 69) cmd = ($urandom_range(0, 99) < call_bias) ? CMD_CALL : CMD_RET;
        else if (sel < 84) cmd = CMD_SETR;
        else if (sel < 98) cmd = CMD_SUB;
        else               cmd = 4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        // keep the stack walk legal; the halting fault is injected at the end
        if (cmd == CMD_CALL && exec_model.depth >= STACK_SLOTS) cmd = CMD_RET;
        else if (cmd == CMD_RET && exec_model.depth == 0)       cmd = CMD_CALL;
        issue_cmd(cmd);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exec_model.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_code_base(input logic [31:0] base);
        @(negedge i_clk);
        i_cfg_code_base <= base;
        i_cfg_valid     <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        exec_model.code_base = base;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!receiver_quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat (pick_gap()) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_result seen;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                seen = '{o_next_address, o_branch_taken, o_fault};
                exec_model.check_result(seen);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [31:0]        phase_base [PHASE_COUNT];
        int                 phase_bias [PHASE_COUNT];
        logic signed [15:0] bad_lo;
        logic signed [15:0] bad_hi;
        exec_model             = new();
        i_rst_n                = 1'b0;
        i_cfg_valid            = 1'b0;
        i_cfg_code_base        = '0;
        i_in_valid             = 1'b0;
        i_cmd                  = '0;
        i_reg_a                = '0;
        i_reg_b                = '0;
        i_reg_c                = '0;
        i_jump_offset          = '0;
        i_range_low            = '0;
        i_range_high           = '0;
        i_random_value         = '0;
        i_fall_through_address = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_code_base(32'hFFFF_FFFF);
        issue(CMD_SETR, 8'd0, 8'd0, 8'd1, 16'h0000, 16'sh8000, 16'sh7FFF, 15'h7FFF, 32'h0);
        issue(CMD_SETR, 8'd0, 8'd0, 8'd2, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 15'h0000,
              32'hFFFF_FFFF);
        issue(CMD_SETR, 8'd0, 8'd0, 8'd3, 16'($urandom), 16'sh8000, 16'sh8000, 15'h5555,
              $urandom);
        issue(CMD_SETR, 8'd0, 8'd0, 8'd4, 16'($urandom), 16'sd0, 16'sd99, 15'd12345, $urandom);
        issue(CMD_SETR, 8'd0, 8'd0, 8'd255, 16'($urandom), -16'sd100, 16'sd100, 15'h2AAA,
              $urandom);
        issue(CMD_SUB, 8'd3, 8'd2, 8'd5, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_SUB, 8'd255, 8'd3, 8'd6, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_JMP, 8'd0, 8'd0, 8'd0, 16'h0000, '0, '0, 15'($urandom), $urandom);
        issue(CMD_JMP, 8'd0, 8'd0, 8'd0, 16'hFFFF, '0, '0, 15'($urandom), $urandom);
        issue(CMD_JGE, 8'd1, 8'd1, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_JGT, 8'd1, 8'd1, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_JGT, 8'd2, 8'd3, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_JGE, 8'd3, 8'd2, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_JEQ, 8'd0, 8'd9, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_JNE, 8'd2, 8'd3, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_JNE, 8'd0, 8'd0, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_BTW, 8'd4, 8'd2, 8'd3, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_BTW, 8'd3, 8'd2, 8'd4, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_RJMP, 8'd4, 8'd0, 8'd0, 16'($urandom), '0, '0, 15'd44, $urandom);
        issue(CMD_RJMP, 8'd4, 8'd0, 8'd0, 16'($urandom), '0, '0, 15'h7FFF, $urandom);
        issue(CMD_RJMP, 8'd3, 8'd0, 8'd0, 16'($urandom), '0, '0, 15'h0000, $urandom);
        issue(CMD_CALL, 8'd0, 8'd0, 8'd0, 16'h1234, '0, '0, 15'($urandom), $urandom);
        issue(CMD_CALL, 8'd0, 8'd0, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_RET, 8'd0, 8'd0, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_RET, 8'd0, 8'd0, 8'd0, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_SPARE_LAST, 8'd1, 8'd2, 8'd3, 16'($urandom), '0, '0, 15'($urandom), $urandom);
        issue(CMD_SPARE_FIRST, 8'd1, 8'd2, 8'd3, 16'($urandom), '0, '0, 15'($urandom),
              $urandom);

        phase_base = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom, 32'h7FFF_FFFF};
        phase_bias = '{50, 70, 40, 60, 50, 30};
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            write_code_base(phase_base[p]);
            call_bias      = phase_bias[p];
            sender_quiet   = (p == 2 || p == 4);
            receiver_quiet = (p == 3 || p == 4);
            repeat (PHASE_ITEMS) random_instr();
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;

        // one halting fault per run; the seed picks which
        case ($urandom_range(0, 2))
            0: begin
                while (exec_model.depth < STACK_SLOTS) issue_cmd(CMD_CALL);
                issue_cmd(CMD_CALL);
            end
            1: begin
                while (exec_model.depth > 0) issue_cmd(CMD_RET);
                issue_cmd(CMD_RET);
            end
            default: begin
                bad_lo = 16'($urandom_range(1, 32767));
                bad_hi = bad_lo - 16'($urandom_range(1, 32767));
                issue(CMD_SETR, pick_reg(), pick_reg(), pick_reg(), 16'($urandom), bad_lo,
                      bad_hi, 15'($urandom), $urandom);
            end
        endcase
        repeat (HALTED_ITEMS) random_instr();
        drain_results();

        if (exec_model.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
